FILE: hdl/aom_pkg.sv
// ----------------------------------------------------------------------------
// aom_pkg: shared types and constants of the adaptive moment optimizer step
// Datapath operation codes, controller/datapath status, configuration indexes
// and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package aom_pkg;

    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_NONE = 4'd0;
    localparam op_t OP_LOAD = 4'd1;
    localparam op_t OP_MUL1 = 4'd2;
    localparam op_t OP_SUM1 = 4'd3;
    localparam op_t OP_DIFF = 4'd4;
    localparam op_t OP_SQ   = 4'd5;
    localparam op_t OP_SQR  = 4'd6;
    localparam op_t OP_MUL2 = 4'd7;
    localparam op_t OP_SUM2 = 4'd8;
    localparam op_t OP_DIV1 = 4'd9;
    localparam op_t OP_DIV2 = 4'd10;
    localparam op_t OP_SQRT = 4'd11;
    localparam op_t OP_DEN  = 4'd12;
    localparam op_t OP_PROD = 4'd13;
    localparam op_t OP_DIV3 = 4'd14;
    localparam op_t OP_EST  = 4'd15;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic in_range;
    } dp_status_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON      = 2'd2;

    localparam logic [15:0] FIRST_DECAY_RST  = 16'd58982;
    localparam logic [15:0] SECOND_DECAY_RST = 16'd65470;
    localparam logic [31:0] EPSILON_RST      = 32'd1;

    localparam int DIV_NUM_W = 72;
    localparam int DIV_DEN_W = 37;
    localparam int DIV_CNT_W = 7;
    localparam int SQRT_CNT_W = 6;

endpackage

FILE: hdl/aom_ctrl.sv
// ----------------------------------------------------------------------------
// aom_ctrl: sequencer of the adaptive moment optimizer step
// Steps the datapath through the moment updates, the two divisions, the
// square root and the final division, then hands the result to the output.
// ----------------------------------------------------------------------------
module aom_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_free,
    output logic                out_load,
    input  aom_pkg::dp_status_t status,
    output aom_pkg::dp_cmd_t    cmd
);
    import aom_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL1 = 4'd1;
    localparam logic [3:0] ST_SUM1 = 4'd2;
    localparam logic [3:0] ST_DIFF = 4'd3;
    localparam logic [3:0] ST_SQ   = 4'd4;
    localparam logic [3:0] ST_SQR  = 4'd5;
    localparam logic [3:0] ST_MUL2 = 4'd6;
    localparam logic [3:0] ST_SUM2 = 4'd7;
    localparam logic [3:0] ST_DIV1 = 4'd8;
    localparam logic [3:0] ST_W1   = 4'd9;
    localparam logic [3:0] ST_W2   = 4'd10;
    localparam logic [3:0] ST_W3   = 4'd11;
    localparam logic [3:0] ST_PROD = 4'd12;
    localparam logic [3:0] ST_DIV3 = 4'd13;
    localparam logic [3:0] ST_W4   = 4'd14;
    localparam logic [3:0] ST_OUT  = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (status.in_range)
                begin
                    cmd.op     = OP_MUL1;
                    state_next = ST_SUM1;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SUM1:
            begin
                cmd.op     = OP_SUM1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.op     = OP_SQR;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = ST_SUM2;
            end
            ST_SUM2:
            begin
                cmd.op     = OP_SUM2;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.op     = OP_DIV1;
                state_next = ST_W1;
            end
            ST_W1:
            begin
                if (!status.busy)
                begin
                    cmd.op     = OP_DIV2;
                    state_next = ST_W2;
                end
            end
            ST_W2:
            begin
                if (!status.busy)
                begin
                    cmd.op     = OP_SQRT;
                    state_next = ST_W3;
                end
            end
            ST_W3:
            begin
                if (!status.busy)
                begin
                    cmd.op     = OP_DEN;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                cmd.op     = OP_PROD;
                state_next = ST_DIV3;
            end
            ST_DIV3:
            begin
                cmd.op     = OP_DIV3;
                state_next = ST_W4;
            end
            ST_W4:
            begin
                if (!status.busy)
                begin
                    cmd.op     = OP_EST;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/aom_dp.sv
// ----------------------------------------------------------------------------
// aom_dp: datapath of the adaptive moment optimizer step
// Holds configuration, the per-parameter stores, the moment arithmetic, a
// shared radix-2 restoring divider and a digit-by-digit square root unit.
// ----------------------------------------------------------------------------
module aom_dp
#(
    parameter int NUM_PARAMS = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [aom_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [aom_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [1:0]                           param_index,
    input  logic signed [31:0]                   gradient,
    input  logic [23:0]                          step_size,
    input  logic [16:0]                          mean_correction,
    input  logic [16:0]                          variance_correction,
    input  aom_pkg::dp_cmd_t                     cmd,
    output aom_pkg::dp_status_t                  status,
    output logic [1:0]                           res_index,
    output logic signed [31:0]                   res_est,
    output logic                                 res_sat
);
    import aom_pkg::*;

    localparam int IDX_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

    logic [15:0] b1_reg;
    logic [15:0] b2_reg;
    logic [31:0] eps_reg;

    logic [31:0] est_mem_reg [NUM_PARAMS];
    logic [31:0] m_mem_reg   [NUM_PARAMS];
    logic [31:0] v_mem_reg   [NUM_PARAMS];

    logic [1:0]         idx_reg;
    logic signed [31:0] g_reg;
    logic [23:0]        alpha_reg;
    logic [16:0]        c1_reg;
    logic [16:0]        c2_reg;
    logic signed [31:0] m_new_reg;
    logic [31:0]        ud_reg;
    logic [63:0]        sqp_reg;
    logic [31:0]        sq_reg;
    logic [31:0]        v_new_reg;
    logic               sat_reg;
    logic [49:0]        pa_reg;
    logic [49:0]        pb_reg;
    logic [47:0]        mhat_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic signed [31:0] res_est_reg;

    logic [DIV_NUM_W-1:0] div_num_reg;
    logic [DIV_DEN_W:0]   div_rem_reg;
    logic [DIV_DEN_W-1:0] div_den_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [63:0]           sx_reg;
    logic [33:0]           srem_reg;
    logic [31:0]           sroot_reg;
    logic [SQRT_CNT_W-1:0] scnt_reg;

    logic [IDX_W+1:0]   idx_ext;
    logic [IDX_W-1:0]   idx_sel;
    logic               in_range;

    logic signed [31:0] m_cur;
    logic signed [31:0] th_cur;
    logic signed [17:0] w1;
    logic [16:0]        w2;
    logic signed [49:0] mul1_a;
    logic signed [49:0] mul1_b;
    logic [49:0]        sum1;
    logic signed [32:0] dif;
    logic [64:0]        sq_round;
    logic [40:0]        sq_full;
    logic [49:0]        sum2;
    logic [31:0]        um;
    logic [DIV_DEN_W-1:0] den_sum;
    logic [DIV_NUM_W-1:0] prod_n;
    logic               q_over;
    logic [33:0]        delta;
    logic signed [34:0] est_wide;
    logic signed [34:0] th_ext;
    logic signed [34:0] delta_ext;
    logic               clip_hi;
    logic               clip_lo;
    logic signed [31:0] est_clip;

    logic [DIV_DEN_W:0]   div_shift;
    logic                 div_bit;
    logic [33:0]          s_shift;
    logic [33:0]          s_trial;
    logic                 s_bit;

    assign idx_ext  = {{IDX_W{1'b0}}, idx_reg};
    assign idx_sel  = idx_ext[IDX_W-1:0];
    assign in_range = idx_ext < (IDX_W + 2)'(NUM_PARAMS);

    assign status.in_range = in_range;
    assign status.busy     = (div_cnt_reg != '0) || (scnt_reg != '0);

    assign m_cur  = $signed(m_mem_reg[idx_sel]);
    assign th_cur = $signed(est_mem_reg[idx_sel]);
    assign w1     = 18'sd65536 - $signed({2'b00, b1_reg});
    assign w2     = 17'd65536 - {1'b0, b2_reg};
    assign mul1_a = 50'($signed({1'b0, b1_reg}) * m_cur);
    assign mul1_b = 50'(w1 * g_reg);
    assign sum1   = pa_reg + pb_reg + 50'd32768;
    assign dif    = {g_reg[31], g_reg} - {m_new_reg[31], m_new_reg};
    assign sq_round = {1'b0, sqp_reg} + 65'd8388608;
    assign sq_full  = sq_round[64:24];
    assign sum2   = pa_reg + pb_reg + 50'd32768;
    assign um     = m_new_reg[31] ? 32'(-m_new_reg) : 32'(m_new_reg);
    assign den_sum = {1'b0, sroot_reg, 4'b0000} + {5'b00000, eps_reg};
    assign prod_n = DIV_NUM_W'(pa_reg[47:0]) + {pb_reg[47:0], 24'd0};

    assign q_over = (div_num_reg[DIV_NUM_W-1:34] != '0)
                    || (div_num_reg[33] && (div_num_reg[32:0] != '0));
    assign delta     = q_over ? 34'h2_0000_0000 : div_num_reg[33:0];
    assign th_ext    = 35'(th_cur);
    assign delta_ext = $signed({1'b0, delta});
    assign est_wide  = m_new_reg[31] ? (th_ext - delta_ext) : (th_ext + delta_ext);
    assign clip_hi   = !est_wide[34] && (est_wide[33:31] != 3'b000);
    assign clip_lo   = est_wide[34] && (est_wide[33:31] != 3'b111);
    assign est_clip  = clip_hi ? 32'sh7FFF_FFFF :
                       clip_lo ? 32'sh8000_0000 : est_wide[31:0];

    assign div_shift = {div_rem_reg[DIV_DEN_W-1:0], div_num_reg[DIV_NUM_W-1]};
    assign div_bit   = div_shift >= {1'b0, div_den_reg};

    assign s_shift = {srem_reg[31:0], sx_reg[63:62]};
    assign s_trial = {sroot_reg, 2'b01};
    assign s_bit   = s_shift >= s_trial;

    // Configuration, stores and unit counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg      <= FIRST_DECAY_RST;
            b2_reg      <= SECOND_DECAY_RST;
            eps_reg     <= EPSILON_RST;
            div_cnt_reg <= '0;
            scnt_reg    <= '0;
            for (int i = 0; i < NUM_PARAMS; i++)
            begin
                est_mem_reg[i] <= '0;
                m_mem_reg[i]   <= '0;
                v_mem_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_DECAY:  b1_reg  <= cfg_data[15:0];
                    CFG_SECOND_DECAY: b2_reg  <= cfg_data[15:0];
                    CFG_EPSILON:      eps_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            if (scnt_reg != '0)
            begin
                scnt_reg <= scnt_reg - 1'b1;
            end
            case (cmd.op)
                OP_SUM2:
                begin
                    if (in_range)
                    begin
                        m_mem_reg[idx_sel] <= m_new_reg;
                        v_mem_reg[idx_sel] <= sum2[47:16];
                    end
                end
                OP_DIV1: div_cnt_reg <= DIV_CNT_W'(48);
                OP_DIV2: div_cnt_reg <= DIV_CNT_W'(64);
                OP_DIV3: div_cnt_reg <= DIV_CNT_W'(DIV_NUM_W);
                OP_SQRT: scnt_reg    <= SQRT_CNT_W'(32);
                OP_EST:
                begin
                    if (in_range)
                    begin
                        est_mem_reg[idx_sel] <= est_clip;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        if (div_cnt_reg != '0)
        begin
            div_num_reg <= {div_num_reg[DIV_NUM_W-2:0], div_bit};
            div_rem_reg <= div_bit ? (div_shift - {1'b0, div_den_reg}) : div_shift;
        end
        if (scnt_reg != '0)
        begin
            sx_reg    <= {sx_reg[61:0], 2'b00};
            srem_reg  <= s_bit ? (s_shift - s_trial) : s_shift;
            sroot_reg <= {sroot_reg[30:0], s_bit};
        end
        case (cmd.op)
            OP_LOAD:
            begin
                idx_reg     <= param_index;
                g_reg       <= gradient;
                alpha_reg   <= step_size;
                c1_reg      <= (mean_correction == '0) ? 17'd1 : mean_correction;
                c2_reg      <= (variance_correction == '0) ? 17'd1 : variance_correction;
                sat_reg     <= 1'b0;
                res_est_reg <= '0;
            end
            OP_MUL1:
            begin
                pa_reg <= mul1_a;
                pb_reg <= mul1_b;
            end
            OP_SUM1: m_new_reg <= sum1[47:16];
            OP_DIFF: ud_reg    <= dif[32] ? 32'(-dif) : 32'(dif);
            OP_SQ:   sqp_reg   <= 64'(ud_reg) * 64'(ud_reg);
            OP_SQR:
            begin
                if (sq_full[40:32] != '0)
                begin
                    sq_reg  <= 32'hFFFF_FFFF;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    sq_reg <= sq_full[31:0];
                end
            end
            OP_MUL2:
            begin
                pa_reg <= 50'(b2_reg * v_mem_reg[idx_sel]);
                pb_reg <= 50'(w2 * sq_reg);
            end
            OP_SUM2: v_new_reg <= sum2[47:16];
            OP_DIV1:
            begin
                div_num_reg <= {um, 40'd0};
                div_rem_reg <= '0;
                div_den_reg <= DIV_DEN_W'(c1_reg);
            end
            OP_DIV2:
            begin
                mhat_reg    <= div_num_reg[47:0];
                div_num_reg <= {v_new_reg, 40'd0};
                div_rem_reg <= '0;
                div_den_reg <= DIV_DEN_W'(c2_reg);
            end
            OP_SQRT:
            begin
                sx_reg    <= div_num_reg[63:0];
                srem_reg  <= '0;
                sroot_reg <= '0;
            end
            OP_DEN: den_reg <= (den_sum == '0) ? DIV_DEN_W'(1) : den_sum;
            OP_PROD:
            begin
                pa_reg <= 50'(alpha_reg * mhat_reg[23:0]);
                pb_reg <= 50'(alpha_reg * mhat_reg[47:24]);
            end
            OP_DIV3:
            begin
                div_num_reg <= prod_n;
                div_rem_reg <= '0;
                div_den_reg <= den_reg;
            end
            OP_EST:
            begin
                res_est_reg <= est_clip;
                sat_reg     <= sat_reg | clip_hi | clip_lo;
            end
            default: ;
        endcase
    end

    assign res_index = idx_reg;
    assign res_est   = res_est_reg;
    assign res_sat   = sat_reg;

endmodule

FILE: hdl/adaptive_moment_optimizer_step.sv
// ----------------------------------------------------------------------------
// adaptive_moment_optimizer_step: AdaBelief-style fixed-point parameter update
// For an index in range, the result enters the output register after the 48,
// 64 and 72 step divisions and the 32 step root; one item is worked at a
// time, and a new item is taken only once the last result has entered the
// output register.
// Reset clears all stores to zero and loads the default configuration.
// ----------------------------------------------------------------------------
module adaptive_moment_optimizer_step
#(
    parameter int NUM_PARAMS = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [aom_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aom_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      param_index,
    input  logic signed [31:0]              gradient,
    input  logic [23:0]                     step_size,
    input  logic [16:0]                     mean_correction,
    input  logic [16:0]                     variance_correction,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      result_index,
    output logic signed [31:0]              new_estimate,
    output logic                            saturated
);
    import aom_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic               out_free;
    logic               out_load;
    logic [1:0]         res_index;
    logic signed [31:0] res_est;
    logic               res_sat;

    logic               out_valid_reg;
    logic [1:0]         result_index_reg;
    logic signed [31:0] new_estimate_reg;
    logic               saturated_reg;

    assign out_free = !out_valid_reg || out_ready;

    aom_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .out_load (out_load),
        .status   (status),
        .cmd      (cmd)
    );

    aom_dp #(.NUM_PARAMS(NUM_PARAMS)) u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .param_index         (param_index),
        .gradient            (gradient),
        .step_size           (step_size),
        .mean_correction     (mean_correction),
        .variance_correction (variance_correction),
        .cmd                 (cmd),
        .status              (status),
        .res_index           (res_index),
        .res_est             (res_est),
        .res_sat             (res_sat)
    );

    // The output register holds a finished result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_index_reg <= res_index;
            new_estimate_reg <= res_est;
            saturated_reg    <= res_sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_index = result_index_reg;
    assign new_estimate = new_estimate_reg;
    assign saturated    = saturated_reg;

endmodule

FILE: bench/adaptive_moment_optimizer_step_tb.sv
// ----------------------------------------------------------------------------
// adaptive_moment_optimizer_step_tb: self-checking bench of the update block
// Drives parameter updates over valid/ready with random idling on both sides,
// predicts each updated estimate in fixed point and compares every transfer
// on the result channel, across several decay and epsilon settings.
// ----------------------------------------------------------------------------
module adaptive_moment_optimizer_step_tb;

    import aom_pkg::*;

    localparam int NPAR      = 4;
    localparam int LATENCY   = 260;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [1:0]         idx;
        logic signed [31:0] est;
        logic               sat;
    } update_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         param_index;
    logic signed [31:0] gradient;
    logic [23:0]        step_size;
    logic [16:0]        mean_correction;
    logic [16:0]        variance_correction;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         result_index;
    logic signed [31:0] new_estimate;
    logic               saturated;

    logic signed [31:0] est_mem [NPAR];
    logic signed [31:0] m_mem [NPAR];
    logic [31:0]        v_mem [NPAR];
    logic [15:0]        b1_reg;
    logic [15:0]        b2_reg;
    logic [31:0]        eps_reg;

    update_t            pending_updates[$];
    int                 mismatches;
    int                 wdog;
    bit                 idle_on;
    bit                 hold_sink;

    adaptive_moment_optimizer_step #(.NUM_PARAMS(NPAR)) dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        begin
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    task automatic predict_update(input logic [1:0] idx, input logic signed [31:0] g,
                                  input logic [23:0] alpha, input logic [16:0] c1_in,
                                  input logic [16:0] c2_in);
        longint signed  m, th, d, est, acc;
        logic [63:0]    ud, sq, um, v, c1, c2, mhat, root, den, q, r, delta;
        logic [127:0]   wide;
        bit             sat;
        update_t        u;
        begin
            sat = 0;
            u.idx = idx;
            u.est = 0;
            u.sat = 0;
            if (idx < NPAR)
            begin
                m = m_mem[idx];
                v = v_mem[idx];
                th = est_mem[idx];
                acc = longint'(b1_reg) * m + (longint'(65536) - b1_reg) * longint'(g) + 32768;
                m = acc >>> 16;
                d = longint'(g) - m;
                ud = (d < 0) ? -d : d;
                sq = (ud * ud + (64'd1 << 23)) >> 24;
                if (sq > 64'hFFFF_FFFF)
                begin
                    sq = 64'hFFFF_FFFF;
                    sat = 1;
                end
                v = (b2_reg * v + (64'd65536 - b2_reg) * sq + 64'd32768) >> 16;
                m_mem[idx] = m[31:0];
                v_mem[idx] = v[31:0];
                c1 = (c1_in == 0) ? 1 : c1_in;
                c2 = (c2_in == 0) ? 1 : c2_in;
                um = (m < 0) ? -m : m;
                mhat = (um << 16) / c1;
                wide = {64'd0, v} << 32;
                root = root64(wide[63:0] / c2) << 4;
                den = root + eps_reg;
                if (den == 0)
                    den = 1;
                q = mhat / den;
                r = mhat % den;
                if (q >= (64'd1 << 40) && alpha != 0)
                    delta = 64'd1 << 33;
                else
                begin
                    delta = alpha * q + (alpha * r) / den;
                    if (delta > (64'd1 << 33))
                        delta = 64'd1 << 33;
                end
                est = (m < 0) ? th - longint'(delta) : th + longint'(delta);
                if (est > 64'sh7FFF_FFFF)
                begin
                    est = 64'sh7FFF_FFFF;
                    sat = 1;
                end
                if (est < -64'sh8000_0000)
                begin
                    est = -64'sh8000_0000;
                    sat = 1;
                end
                est_mem[idx] = est[31:0];
                u.est = est[31:0];
                u.sat = sat;
            end
            pending_updates.push_back(u);
        end
    endtask

    task automatic send_update(input logic [1:0] idx, input logic signed [31:0] g,
                               input logic [23:0] alpha, input logic [16:0] c1,
                               input logic [16:0] c2);
        int gap;
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            param_index <= idx;
            gradient <= g;
            step_size <= alpha;
            mean_correction <= c1;
            variance_correction <= c2;
            predict_update(idx, g, alpha, c1, c2);
            do
                @(posedge clk);
            while (!in_ready);
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            while (pending_updates.size() != 0)
                @(negedge clk);
            repeat (LATENCY) @(negedge clk);
        end
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        begin
            wait_drained();
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(negedge clk);
            cfg_we <= 1'b0;
            if (idx == CFG_FIRST_DECAY)
                b1_reg = val[15:0];
            else if (idx == CFG_SECOND_DECAY)
                b2_reg = val[15:0];
            else if (idx == CFG_EPSILON)
                eps_reg = val;
        end
    endtask

    task automatic send_random(input int n);
        logic [31:0] g;
        int          k;
        begin
            for (k = 0; k < n; k++)
            begin
                case ($urandom_range(0, 3))
                    0: g = $urandom;
                    1: g = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                    2: g = {{8{1'b0}}, 24'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
                    default: g = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                endcase
                send_update(2'($urandom), g, 24'($urandom),
                            ($urandom_range(0, 9) == 0) ? 17'd0 : 17'($urandom_range(1, 65536)),
                            ($urandom_range(0, 9) == 0) ? 17'd0 : 17'($urandom_range(1, 65536)));
            end
        end
    endtask

    task automatic test_directed();
        begin
            send_update(2'd0, 32'sh0100_0000, 24'hFF_FFFF, 17'd65536, 17'd65536);
            send_update(2'd0, 32'sh7FFF_FFFF, 24'hFF_FFFF, 17'd1, 17'd1);
            send_update(2'd1, 32'sh8000_0000, 24'hFF_FFFF, 17'd1, 17'd65536);
            send_update(2'd1, 32'sh8000_0000, 24'hFF_FFFF, 17'd1, 17'd1);
            send_update(2'd2, 32'sd0, 24'd0, 17'd0, 17'd0);
            send_update(2'd2, -32'sd1, 24'd1, 17'h1_FFFF, 17'h1_FFFF);
            send_update(2'd3, 32'sh7FFF_FFFF, 24'd0, 17'd65536, 17'd0);
            send_update(2'd3, 32'sh0000_0001, 24'h80_0000, 17'd32768, 17'd32768);
            send_update(2'd0, 32'shFF00_0000, 24'h00_1000, 17'd0, 17'd65536);
        end
    endtask

    task automatic test_config_extremes();
        begin
            write_config(CFG_FIRST_DECAY, 32'd0);
            write_config(CFG_SECOND_DECAY, 32'd0);
            write_config(CFG_EPSILON, 32'd0);
            send_update(2'd1, 32'sd0, 24'hFF_FFFF, 17'd1, 17'd1);
            send_update(2'd2, 32'sh0000_0100, 24'hFF_FFFF, 17'd1, 17'd1);
            send_random(40);
            write_config(CFG_FIRST_DECAY, 32'd65535);
            write_config(CFG_SECOND_DECAY, 32'd65535);
            write_config(CFG_EPSILON, 32'hFFFF_FFFF);
            send_random(40);
            write_config(CFG_FIRST_DECAY, 32'd58982);
            write_config(CFG_SECOND_DECAY, 32'd65470);
            write_config(CFG_EPSILON, 32'd16777);
        end
    endtask

    task automatic test_backpressure();
        begin
            hold_sink = 1'b1;
            send_random(4);
            hold_sink = 1'b0;
            wait_drained();
        end
    endtask

    task automatic test_random_bulk();
        begin
            send_random(220);
            write_config(CFG_FIRST_DECAY, 32'($urandom));
            write_config(CFG_SECOND_DECAY, 32'($urandom));
            write_config(CFG_EPSILON, $urandom_range(0, 2000));
            send_random(220);
            idle_on = 1'b0;
            send_random(60);
        end
    endtask

    always @(posedge clk)
    begin
        update_t exp_u;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result idx=%0d est=%0d", result_index, new_estimate);
            end
            else
            begin
                exp_u = pending_updates.pop_front();
                if (result_index !== exp_u.idx || new_estimate !== exp_u.est
                    || saturated !== exp_u.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx=%0d est=%0d sat=%0b got idx=%0d est=%0d sat=%0b",
                                 exp_u.idx, exp_u.est, exp_u.sat,
                                 result_index, new_estimate, saturated);
                end
            end
        end
    end

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                out_ready <= 1'b0;
                gap = 0;
                while (gap < 1500)
                begin
                    @(negedge clk);
                    gap++;
                end
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        param_index = '0;
        gradient = '0;
        step_size = '0;
        mean_correction = 17'd1;
        variance_correction = 17'd1;
        mismatches = 0;
        wdog = 0;
        idle_on = 1'b1;
        hold_sink = 1'b0;
        b1_reg = FIRST_DECAY_RST;
        b2_reg = SECOND_DECAY_RST;
        eps_reg = EPSILON_RST;
        for (int i = 0; i < NPAR; i++)
        begin
            est_mem[i] = 0;
            m_mem[i] = 0;
            v_mem[i] = 0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_bulk();
        wait_drained();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
